[hw/rtl/idxh_pkg.sv]
// ----------------------------------------------------------------------------
// idxh_pkg
// Shared constants for the indexed min-heap: stream widths, field offsets and
// operation and status codes.
// ----------------------------------------------------------------------------
package idxh_pkg;

  // stream widths, whole bytes
  localparam int S_DATA_W = 48;
  localparam int M_DATA_W = 48;

  // input field widths and offsets in s_tdata
  localparam int VERTEX_W = 10;
  localparam int IN_KEY_W = 32;
  localparam int IN_VERTEX_LO = 0;
  localparam int IN_KEY_LO = 10;

  // operation codes carried on s_tuser
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  // status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

endpackage

[hw/rtl/indexed_min_heap_decrease_key_top.sv]
// ----------------------------------------------------------------------------
// indexed_min_heap_decrease_key_top
// Indexed binary min-heap over vertex ids with insert, decrease-key and pop.
// ----------------------------------------------------------------------------
// Input stream s_*: one item per operation; s_tuser selects push (0) or pop
// (1), s_tdata carries the vertex id and its signed key. Output stream m_*:
// one item per input item with status, updated flag, popped vertex and key,
// and whether the heap is now empty.
// A push looks up the vertex's position, then sifts up level by level (a
// decrease-key first compares the new key with the stored one); a pop reads the
// root and the last entry, then sifts down level by level. Each level is
// one registered read of the slot memory, a compare and one write of the slot
// and position memories.
// One item is worked on at a time; s_tready is high while the sequencer idles.
// After reset a clearing pass marks every vertex absent, during which
// s_tready stays low.
// A finished result waits in the output register; the next item is accepted
// meanwhile, and is held at its end until m_tready frees that register.
// ----------------------------------------------------------------------------
module indexed_min_heap_decrease_key_top #(
  parameter int VERTICES = 1024,
  parameter int KEY_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // vertex [9:0], new_key [41:10], zero fill above
  input  logic [idxh_pkg::S_DATA_W-1:0] s_tdata,
  // action
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // status [0], updated [1], out_vertex [11:2], out_key [43:12],
  // now_empty [44], zero fill above
  output logic [idxh_pkg::M_DATA_W-1:0] m_tdata
);

  localparam int IW = $clog2(VERTICES);
  localparam int HW = IW + KEY_BITS;

  logic          h_we;
  logic [IW-1:0] h_waddr;
  logic [HW-1:0] h_wdata;
  logic [IW-1:0] h_raddr_a;
  logic [HW-1:0] h_rdata_a;
  logic [IW-1:0] h_raddr_b;
  logic [HW-1:0] h_rdata_b;
  logic          p_we;
  logic [IW-1:0] p_waddr;
  logic [IW:0]   p_wdata;
  logic [IW-1:0] p_raddr;
  logic [IW:0]   p_rdata;

  // slot memory: vertex and key of each heap slot
  idxh_ram_2r #(
    .DEPTH (VERTICES),
    .WIDTH (HW)
  ) u_slots (
    .clk     (clk),
    .we      (h_we),
    .waddr   (h_waddr),
    .wdata   (h_wdata),
    .raddr_a (h_raddr_a),
    .rdata_a (h_rdata_a),
    .raddr_b (h_raddr_b),
    .rdata_b (h_rdata_b)
  );

  // position memory: presence bit and slot of each vertex
  idxh_ram_1r #(
    .DEPTH (VERTICES),
    .WIDTH (IW + 1)
  ) u_pos (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  // sequencer
  idxh_ctrl #(
    .VERTICES (VERTICES),
    .KEY_BITS (KEY_BITS),
    .IW       (IW),
    .HW       (HW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .h_we      (h_we),
    .h_waddr   (h_waddr),
    .h_wdata   (h_wdata),
    .h_raddr_a (h_raddr_a),
    .h_rdata_a (h_rdata_a),
    .h_raddr_b (h_raddr_b),
    .h_rdata_b (h_rdata_b),
    .p_we      (p_we),
    .p_waddr   (p_waddr),
    .p_wdata   (p_wdata),
    .p_raddr   (p_raddr),
    .p_rdata   (p_rdata)
  );

endmodule

[hw/rtl/idxh_ram_1r.sv]
// ----------------------------------------------------------------------------
// idxh_ram_1r
// Synchronous memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module idxh_ram_1r #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 11
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/idxh_ram_2r.sv]
// ----------------------------------------------------------------------------
// idxh_ram_2r
// Synchronous memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module idxh_ram_2r #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 42
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // two registered reads
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[hw/rtl/idxh_ctrl.sv]
// ----------------------------------------------------------------------------
// idxh_ctrl
// Sequencer of the indexed min-heap: clearing pass, push with sift-up and
// pop with sift-down, carrying the moving entry in registers (hole method).
// ----------------------------------------------------------------------------
module idxh_ctrl #(
  parameter int VERTICES = 1024,
  parameter int KEY_BITS = 32,
  parameter int IW       = $clog2(VERTICES),
  parameter int HW       = IW + KEY_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [idxh_pkg::S_DATA_W-1:0] s_tdata,
  input  logic                         s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [idxh_pkg::M_DATA_W-1:0] m_tdata,
  output logic                         h_we,
  output logic [IW-1:0]                h_waddr,
  output logic [HW-1:0]                h_wdata,
  output logic [IW-1:0]                h_raddr_a,
  input  logic [HW-1:0]                h_rdata_a,
  output logic [IW-1:0]                h_raddr_b,
  input  logic [HW-1:0]                h_rdata_b,
  output logic                         p_we,
  output logic [IW-1:0]                p_waddr,
  output logic [IW:0]                  p_wdata,
  output logic [IW-1:0]                p_raddr,
  input  logic [IW:0]                  p_rdata
);

  localparam int CW = $clog2(VERTICES + 1);
  localparam int VW = (IW > idxh_pkg::VERTEX_W) ? IW : idxh_pkg::VERTEX_W;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_CLR    = 10'b0000000010,
    ST_P_LOOK = 10'b0000000100,
    ST_P_KEY  = 10'b0000001000,
    ST_UP     = 10'b0000010000,
    ST_UP_CMP = 10'b0000100000,
    ST_D_ROOT = 10'b0001000000,
    ST_DN     = 10'b0010000000,
    ST_DN_CMP = 10'b0100000000,
    ST_DONE   = 10'b1000000000
  } state_t;

  state_t              state;
  logic [IW-1:0]       clr_idx;
  logic [CW-1:0]       cnt;
  logic [IW-1:0]       cur_v;
  logic                cur_ok;
  logic [KEY_BITS-1:0] cur_k;
  logic [IW-1:0]       slot;
  logic                res_status;
  logic                res_updated;
  logic [IW-1:0]       res_vertex;
  logic [KEY_BITS-1:0] res_key;

  // input decode
  logic [VW-1:0]       in_v;
  logic                in_ok;
  logic [KEY_BITS-1:0] in_k;
  assign in_v  = VW'(s_tdata[idxh_pkg::IN_VERTEX_LO +: idxh_pkg::VERTEX_W]);
  assign in_ok = {1'b0, in_v} < (VW+1)'(VERTICES);
  assign in_k  = KEY_BITS'(s_tdata[idxh_pkg::IN_KEY_LO +: idxh_pkg::IN_KEY_W]);

  // heap geometry around the hole
  logic [IW-1:0]       parent;
  logic [IW+1:0]       lchild;
  logic [IW+1:0]       rchild;
  logic                l_ok;
  logic                r_ok;
  assign parent = IW'((slot - 1'b1) >> 1);
  assign lchild = {1'b0, slot, 1'b1};
  assign rchild = lchild + (IW+2)'(1);
  assign l_ok   = lchild < (IW+2)'(cnt);
  assign r_ok   = rchild < (IW+2)'(cnt);

  // fields of the entries read back
  logic [IW-1:0]       a_v;
  logic [KEY_BITS-1:0] a_k;
  logic [IW-1:0]       b_v;
  logic [KEY_BITS-1:0] b_k;
  assign a_v = h_rdata_a[HW-1:KEY_BITS];
  assign a_k = h_rdata_a[KEY_BITS-1:0];
  assign b_v = h_rdata_b[HW-1:KEY_BITS];
  assign b_k = h_rdata_b[KEY_BITS-1:0];

  // sift-down child choice, left wins ties
  logic                go_l;
  logic                go_r;
  logic [KEY_BITS-1:0] best_k;
  always_comb begin
    go_l   = 1'b0;
    go_r   = 1'b0;
    best_k = cur_k;
    if (l_ok && ($signed(a_k) < $signed(cur_k))) begin
      go_l   = 1'b1;
      best_k = a_k;
    end
    if (r_ok && ($signed(b_k) < $signed(best_k))) begin
      go_r = 1'b1;
      go_l = 1'b0;
    end
  end

  logic up_move;
  assign up_move = $signed(a_k) > $signed(cur_k);

  logic out_free;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  // memory port drive
  always_comb begin
    h_we      = 1'b0;
    h_waddr   = slot;
    h_wdata   = {cur_v, cur_k};
    h_raddr_a = '0;
    h_raddr_b = IW'(cnt - 1'b1);
    p_we      = 1'b0;
    p_waddr   = cur_v;
    p_wdata   = {1'b1, slot};
    p_raddr   = in_v[IW-1:0];
    unique case (state)
      ST_CLR: begin
        p_we    = 1'b1;
        p_waddr = clr_idx;
        p_wdata = '0;
      end
      ST_P_LOOK: begin
        h_raddr_a = p_rdata[IW-1:0];
      end
      ST_UP: begin
        h_raddr_a = parent;
        if (slot == '0) begin
          h_we = 1'b1;
          p_we = 1'b1;
        end
      end
      ST_UP_CMP: begin
        h_we = 1'b1;
        p_we = 1'b1;
        if (up_move) begin
          h_wdata = h_rdata_a;
          p_waddr = a_v;
        end
      end
      ST_D_ROOT: begin
        p_we    = 1'b1;
        p_waddr = a_v;
        p_wdata = '0;
      end
      ST_DN: begin
        h_raddr_a = IW'(lchild);
        h_raddr_b = IW'(rchild);
      end
      ST_DN_CMP: begin
        h_we = 1'b1;
        p_we = 1'b1;
        if (go_r) begin
          h_wdata = h_rdata_b;
          p_waddr = b_v;
        end else if (go_l) begin
          h_wdata = h_rdata_a;
          p_waddr = a_v;
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLR;
      clr_idx  <= '0;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if ((state == ST_DONE) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == IW'(VERTICES - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            cur_v       <= in_v[IW-1:0];
            cur_ok      <= in_ok;
            cur_k       <= in_k;
            res_status  <= idxh_pkg::STATUS_OK;
            res_updated <= 1'b0;
            res_vertex  <= '0;
            res_key     <= '0;
            if (s_tuser == idxh_pkg::ACT_PUSH) begin
              state <= ST_P_LOOK;
            end else if (cnt == '0) begin
              res_status <= idxh_pkg::STATUS_EMPTY;
              state      <= ST_DONE;
            end else begin
              state <= ST_D_ROOT;
            end
          end
        end
        ST_P_LOOK: begin
          if (!cur_ok) begin
            state <= ST_DONE;
          end else if (!p_rdata[IW]) begin
            if (cnt < CW'(VERTICES)) begin
              slot        <= IW'(cnt);
              cnt         <= cnt + 1'b1;
              res_updated <= 1'b1;
              state       <= ST_UP;
            end else begin
              state <= ST_DONE;
            end
          end else begin
            slot  <= p_rdata[IW-1:0];
            state <= ST_P_KEY;
          end
        end
        ST_P_KEY: begin
          if ($signed(cur_k) < $signed(a_k)) begin
            res_updated <= 1'b1;
            state       <= ST_UP;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_UP: begin
          state <= (slot == '0) ? ST_DONE : ST_UP_CMP;
        end
        ST_UP_CMP: begin
          if (up_move) begin
            slot  <= parent;
            state <= ST_UP;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_D_ROOT: begin
          res_vertex <= a_v;
          res_key    <= a_k;
          cnt        <= cnt - 1'b1;
          cur_v      <= b_v;
          cur_k      <= b_k;
          slot       <= '0;
          state      <= (cnt == CW'(1)) ? ST_DONE : ST_DN;
        end
        ST_DN: begin
          state <= ST_DN_CMP;
        end
        ST_DN_CMP: begin
          if (go_r) begin
            slot  <= IW'(rchild);
            state <= ST_DN;
          end else if (go_l) begin
            slot  <= IW'(lchild);
            state <= ST_DN;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result register, loaded when the item finishes
  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      m_tdata <= {3'b000, (cnt == '0), 32'(res_key), 10'(res_vertex),
                  res_updated, res_status};
    end
  end

`ifndef ASSERT_OFF
  // entry count never exceeds the capacity
  a_cnt_cap: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(VERTICES))
    else $error("entry count above capacity");

  // entry count moves by at most one per cycle
  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    (cnt == $past(cnt)) || (cnt == $past(cnt) + 1'b1) || (cnt == $past(cnt) - 1'b1))
    else $error("entry count jumped");

  // the hole always lies inside the heap while sifting
  a_hole_in: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_UP_CMP) || (state == ST_DN_CMP)) |-> (CW'(slot) < cnt))
    else $error("hole outside the heap");

  // a result is only raised from the finishing state
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_DONE))
    else $error("result raised outside finish");
`endif

endmodule
